// ----- design/assert_macros.svh -----
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ----- design/skp_pkg.sv -----
package skp_pkg;

    localparam int MAX_LEVELS = 64;
    localparam int COORD_BITS = 13;
    localparam int LVL_AW     = $clog2(MAX_LEVELS);
    localparam int CNT_W      = $clog2(MAX_LEVELS + 1);
    localparam int AREA_W     = 2 * COORD_BITS;
    localparam int POS_BITS   = COORD_BITS - 1;

    localparam logic [COORD_BITS-1:0] BIN_CAP     = COORD_BITS'(1) << (COORD_BITS - 1);
    localparam logic [COORD_BITS-1:0] RESET_WIDTH = COORD_BITS'(1024);
    localparam logic [COORD_BITS-1:0] RESET_HEIGHT = COORD_BITS'(1024);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_PROBE  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NOFIT = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CFG_BIN_WIDTH  = 2'd0,
        CFG_BIN_HEIGHT = 2'd1,
        CFG_HEURISTIC  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [COORD_BITS-1:0] start;
        logic [COORD_BITS-1:0] span;
        logic [COORD_BITS-1:0] top;
    } t_level;

endpackage

// ----- design/skyline_rect_packer.sv -----
// Skyline rectangle packer.
// Input stream: one word per request; tdata holds op, rect_width, rect_height and
// may_rotate from bit 0 up. op 0 inserts, 1 probes, 2 clears the skyline to one level.
// Output stream: one word per request with status, position and placed size.
// Configuration: i_cfg_we/i_cfg_idx/i_cfg_data write bin width, bin height and
// the scoring heuristic; write them only while no request is in flight.
// The skyline lives in one level memory split in two banks; an insert walks
// the active bank and builds the new skyline in the other bank, then swaps.
// Each candidate start walks the levels it covers (plus a waste walk over its
// levels for each waste pass in best-fit mode), for both orientations when
// flipping is allowed; an insert then rebuilds the skyline level by level.
// One request is processed at a time; the next one is accepted once the
// current result sits in the output register, even while the receiver stalls.
// After reset the block writes the initial level (width 1024) in its init state
// before it accepts a word; registers reset to 1024, 1024, bottom-left.
module skyline_rect_packer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [skp_pkg::COORD_BITS-1:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // op[1:0], rect_width[14:2], rect_height[27:15], may_rotate[28], zero fill
    input  logic [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[1:0], pos_x[13:2], pos_y[25:14], placed_width[38:26],
    // placed_height[51:39], zero fill
    output logic [55:0] m_axis_tdata
);
    import skp_pkg::*;

    `include "assert_macros.svh"

    typedef enum logic [15:0] {
        S_INIT  = 16'h0001,
        S_IDLE  = 16'h0002,
        S_CAND  = 16'h0004,
        S_FRD   = 16'h0008,
        S_FCHK  = 16'h0010,
        S_WRD   = 16'h0020,
        S_WCHK  = 16'h0040,
        S_WACC  = 16'h0080,
        S_WEND  = 16'h0100,
        S_CMP   = 16'h0200,
        S_NEXT  = 16'h0400,
        S_END   = 16'h0800,
        S_PRD   = 16'h1000,
        S_PPUSH = 16'h2000,
        S_FLUSH = 16'h4000,
        S_DONE  = 16'h8000
    } t_state;

    localparam int CB = COORD_BITS;

    t_state r_state;

    logic [CB-1:0] r_bin_w, r_bin_h;
    logic          r_heur;

    t_level mem [2*MAX_LEVELS];
    t_level r_rdata;
    logic   r_bank;
    logic [CNT_W-1:0] r_cnt;

    t_op           r_op;
    logic [CB-1:0] r_w, r_h;
    logic          r_flip;

    logic [LVL_AW-1:0] r_idx;
    logic              r_or;
    logic [CNT_W-1:0]  r_k;
    logic [CB-1:0]     r_y, r_rest, r_x0, r_sp0, r_left;

    logic [CB:0]       r_wx0;
    logic              r_wpass, r_wbrk;
    logic [AREA_W-1:0] r_area, r_prod;

    logic [AREA_W-1:0] r_c0;
    logic [CB:0]       r_c1;
    logic [CB-1:0]     r_cx;

    logic              r_bv;
    logic [AREA_W-1:0] r_bs0;
    logic [CB:0]       r_bs1;
    logic [CB-1:0]     r_bx, r_by, r_bw, r_bh;

    logic [1:0]       r_sub;
    logic [CNT_W-1:0] r_nc;
    logic             r_pv;
    logic [CB-1:0]    r_ps, r_plen, r_ptop;

    t_status       r_rs_status;
    logic [CB-1:0] r_rs_x, r_rs_y, r_rs_w, r_rs_h;

    logic       r_ovalid;
    logic [1:0] r_o_status;
    logic [POS_BITS-1:0] r_o_x, r_o_y;
    logic [CB-1:0] r_o_w, r_o_h;

    // Combinational helpers.
    logic [CB-1:0] eff_w, eff_h, cw, ch;
    logic          first;
    logic [CB-1:0] fy, frest, fx0, fsp0;
    logic          fstart_bad;
    logic [CB:0]   rd_end, fyh;
    logic [CB:0]   wx1, wa, wb;
    logic [CB-1:0] top_new;
    logic [CB:0]   px1, pa, pb;
    logic          pover;
    logic [CB-1:0] pc_s, pc_len, pc_top;
    logic          pc_last, pu_zero, pu_merge, pu_full, pu_wr;
    logic [CNT_W-1:0] k_inc, idx_inc;
    logic          mem_we, mem_re;
    logic [LVL_AW:0] mem_wa, mem_ra;
    t_level        mem_wd;

    always_comb begin
        eff_w  = (r_bin_w > BIN_CAP) ? BIN_CAP : r_bin_w;
        eff_h  = (r_bin_h > BIN_CAP) ? BIN_CAP : r_bin_h;
        cw     = r_or ? r_h : r_w;
        ch     = r_or ? r_w : r_h;
        first  = (r_k == CNT_W'(r_idx));
        rd_end = {1'b0, r_rdata.start} + {1'b0, r_rdata.span};
        fy     = first ? r_rdata.top : ((r_rdata.top > r_y) ? r_rdata.top : r_y);
        frest  = first ? cw : r_rest;
        fx0    = first ? r_rdata.start : r_x0;
        fsp0   = first ? r_rdata.span : r_sp0;
        fstart_bad = first && (({1'b0, r_rdata.start} + {1'b0, cw}) > {1'b0, eff_w});
        fyh    = {1'b0, fy} + {1'b0, ch};
        k_inc  = r_k + CNT_W'(1);
        idx_inc = CNT_W'(r_idx) + CNT_W'(1);

        wx1 = r_wx0 + {1'b0, cw};
        wa  = (r_wx0 > {1'b0, r_rdata.start}) ? r_wx0 : {1'b0, r_rdata.start};
        wb  = (wx1 < rd_end) ? wx1 : rd_end;

        top_new = r_by + r_bh;
        px1   = {1'b0, r_bx} + {1'b0, r_bw};
        pa    = ({1'b0, r_bx} > {1'b0, r_rdata.start}) ? {1'b0, r_bx} : {1'b0, r_rdata.start};
        pb    = (px1 < rd_end) ? px1 : rd_end;
        pover = pb > pa;
        pc_last = !pover || (r_sub == 2'd2);
        if (!pover) begin
            pc_s = r_rdata.start; pc_len = r_rdata.span; pc_top = r_rdata.top;
        end else begin
            case (r_sub)
                2'd0: begin
                    pc_s = r_rdata.start;
                    pc_len = CB'(pa - {1'b0, r_rdata.start});
                    pc_top = r_rdata.top;
                end
                2'd1: begin
                    pc_s = pa[CB-1:0]; pc_len = CB'(pb - pa); pc_top = top_new;
                end
                default: begin
                    pc_s = pb[CB-1:0]; pc_len = CB'(rd_end - pb); pc_top = r_rdata.top;
                end
            endcase
        end
        pu_zero  = (pc_len == '0);
        pu_merge = r_pv && (r_ptop == pc_top);
        pu_full  = ((r_nc + CNT_W'(r_pv)) >= CNT_W'(MAX_LEVELS));
        pu_wr    = !pu_zero && !pu_merge && !pu_full && r_pv;

        mem_re = (r_state == S_FRD) || (r_state == S_WRD) || (r_state == S_PRD);
        mem_ra = {r_bank, r_k[LVL_AW-1:0]};
        mem_we = 1'b0;
        mem_wa = '0;
        mem_wd = '{start: '0, span: r_bin_w, top: '0};
        case (r_state)
            S_INIT: begin
                mem_we = 1'b1;
                mem_wd = '{start: '0, span: RESET_WIDTH, top: '0};
            end
            S_END: begin
                mem_we = (r_op == OP_CLEAR);
                mem_wa = {r_bank, LVL_AW'(0)};
            end
            S_PPUSH: begin
                mem_we = pu_wr;
                mem_wa = {~r_bank, r_nc[LVL_AW-1:0]};
                mem_wd = '{start: r_ps, span: r_plen, top: r_ptop};
            end
            S_FLUSH: begin
                mem_we = r_pv;
                mem_wa = {~r_bank, r_nc[LVL_AW-1:0]};
                mem_wd = '{start: r_ps, span: r_plen, top: r_ptop};
            end
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_ra];
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {4'd0, r_o_h, r_o_w, r_o_y, r_o_x, r_o_status};

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_w <= RESET_WIDTH;
            r_bin_h <= RESET_HEIGHT;
            r_heur  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BIN_WIDTH:  r_bin_w <= i_cfg_data;
                CFG_BIN_HEIGHT: r_bin_h <= i_cfg_data;
                CFG_HEURISTIC:  r_heur  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_DONE && (!r_ovalid || m_axis_tready)) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_ovalid || m_axis_tready)) begin
            r_o_status <= r_rs_status;
            r_o_x      <= r_rs_x[POS_BITS-1:0];
            r_o_y      <= r_rs_y[POS_BITS-1:0];
            r_o_w      <= r_rs_w;
            r_o_h      <= r_rs_h;
        end
    end

    // Main sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_bank  <= 1'b0;
            r_cnt   <= CNT_W'(1);
            r_bv    <= 1'b0;
            r_pv    <= 1'b0;
            r_nc    <= '0;
        end else begin
            case (r_state)
                S_INIT: r_state <= S_IDLE;
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_op   <= t_op'(s_axis_tdata[1:0]);
                        r_w    <= s_axis_tdata[14:2];
                        r_h    <= s_axis_tdata[27:15];
                        r_flip <= s_axis_tdata[28];
                        r_bv   <= 1'b0;
                        r_idx  <= '0;
                        r_or   <= 1'b0;
                        if (s_axis_tdata[1:0] == OP_INSERT || s_axis_tdata[1:0] == OP_PROBE) begin
                            r_state <= S_CAND;
                        end else begin
                            r_state <= S_END;
                        end
                    end
                end
                S_CAND: begin
                    r_k <= CNT_W'(r_idx);
                    r_state <= (cw == '0) ? S_NEXT : S_FRD;
                end
                S_FRD: r_state <= S_FCHK;
                S_FCHK: begin
                    r_y   <= fy;
                    r_x0  <= fx0;
                    r_sp0 <= fsp0;
                    if (fstart_bad) begin
                        r_state <= S_NEXT;
                    end else if (frest > r_rdata.span) begin
                        r_rest <= frest - r_rdata.span;
                        r_k    <= k_inc;
                        r_state <= (k_inc >= r_cnt) ? S_NEXT : S_FRD;
                    end else if (fyh > {1'b0, eff_h}) begin
                        r_state <= S_NEXT;
                    end else begin
                        r_left <= r_rdata.span - frest;
                        if (r_op == OP_PROBE) begin
                            r_bv    <= 1'b1;
                            r_state <= S_END;
                        end else if (!r_heur) begin
                            r_c0    <= AREA_W'(fyh);
                            r_c1    <= {1'b0, fsp0};
                            r_cx    <= fx0;
                            r_state <= S_CMP;
                        end else begin
                            r_wx0   <= {1'b0, fx0};
                            r_area  <= '0;
                            r_wpass <= 1'b0;
                            r_k     <= CNT_W'(r_idx);
                            r_state <= S_WRD;
                        end
                    end
                end
                S_WRD: r_state <= S_WCHK;
                S_WCHK: begin
                    if (r_wx0 >= rd_end) begin
                        r_k <= k_inc;
                        r_state <= (k_inc >= r_cnt) ? S_WEND : S_WRD;
                    end else begin
                        if (wb > wa && r_y > r_rdata.top) begin
                            r_prod <= CB'(wb - wa) * (r_y - r_rdata.top);
                        end else begin
                            r_prod <= '0;
                        end
                        r_wbrk  <= (wb >= wx1);
                        r_state <= S_WACC;
                    end
                end
                S_WACC: begin
                    r_area <= r_area + r_prod;
                    if (r_wbrk || k_inc >= r_cnt) begin
                        r_state <= S_WEND;
                    end else begin
                        r_k <= k_inc;
                        r_state <= S_WRD;
                    end
                end
                S_WEND: begin
                    if (!r_wpass) begin
                        r_c0 <= r_area;
                        r_c1 <= {1'b0, r_y} + {1'b0, ch};
                        r_cx <= r_x0;
                        if (r_left != '0) begin
                            r_wpass <= 1'b1;
                            r_wx0   <= {1'b0, r_x0} + {1'b0, r_left};
                            r_area  <= '0;
                            r_k     <= CNT_W'(r_idx);
                            r_state <= S_WRD;
                        end else begin
                            r_state <= S_CMP;
                        end
                    end else begin
                        // Right-aligned spot has the same top, so only the waste decides.
                        if (r_area < r_c0) begin
                            r_c0 <= r_area;
                            r_cx <= r_wx0[CB-1:0];
                        end
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (!r_bv || r_c0 < r_bs0 || (r_c0 == r_bs0 && r_c1 < r_bs1)) begin
                        r_bv  <= 1'b1;
                        r_bs0 <= r_c0;
                        r_bs1 <= r_c1;
                        r_bx  <= r_cx;
                        r_by  <= r_y;
                        r_bw  <= cw;
                        r_bh  <= ch;
                    end
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    if (!r_or && r_flip) begin
                        r_or    <= 1'b1;
                        r_state <= S_CAND;
                    end else begin
                        r_or  <= 1'b0;
                        r_idx <= r_idx + LVL_AW'(1);
                        r_state <= (idx_inc >= r_cnt) ? S_END : S_CAND;
                    end
                end
                S_END: begin
                    r_rs_x <= '0; r_rs_y <= '0; r_rs_w <= '0; r_rs_h <= '0;
                    case (r_op)
                        OP_CLEAR: begin
                            r_cnt <= CNT_W'(1);
                            r_rs_status <= ST_OK;
                            r_state <= S_DONE;
                        end
                        OP_PROBE: begin
                            if (r_bv) begin
                                r_rs_status <= ST_OK;
                            end else begin
                                r_rs_status <= ST_NOFIT;
                            end
                            r_state <= S_DONE;
                        end
                        OP_INSERT: begin
                            r_rs_status <= ST_NOFIT;
                            if (r_bv) begin
                                r_k   <= '0;
                                r_sub <= 2'd0;
                                r_nc  <= '0;
                                r_pv  <= 1'b0;
                                r_state <= S_PRD;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                        default: begin
                            r_rs_status <= ST_NOFIT;
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_PRD: begin
                    r_sub   <= 2'd0;
                    r_state <= S_PPUSH;
                end
                S_PPUSH: begin
                    if (!pu_zero && !pu_merge && pu_full) begin
                        r_rs_status <= ST_FULL;
                        r_state <= S_DONE;
                    end else begin
                        if (pu_merge && !pu_zero) begin
                            r_plen <= r_plen + pc_len;
                        end else if (!pu_zero) begin
                            if (r_pv) begin
                                r_nc <= r_nc + CNT_W'(1);
                            end
                            r_pv   <= 1'b1;
                            r_ps   <= pc_s;
                            r_plen <= pc_len;
                            r_ptop <= pc_top;
                        end
                        if (pc_last) begin
                            r_k <= k_inc;
                            r_state <= (k_inc >= r_cnt) ? S_FLUSH : S_PRD;
                        end else begin
                            r_sub <= r_sub + 2'd1;
                        end
                    end
                end
                S_FLUSH: begin
                    r_bank <= ~r_bank;
                    r_cnt  <= r_nc + CNT_W'(r_pv);
                    r_rs_status <= ST_OK;
                    r_rs_x <= r_bx;
                    r_rs_y <= r_by;
                    r_rs_w <= r_bw;
                    r_rs_h <= r_bh;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ASSERT_CLK(a_cnt_range, (r_cnt != '0) && (r_cnt <= CNT_W'(MAX_LEVELS)),
        "level count out of range")
    `ASSERT_CLK(a_build_bank, (r_state == S_PPUSH && mem_we) |-> (mem_wa[LVL_AW] != r_bank),
        "rebuild writes into the active bank")
    `ASSERT_CLK(a_flush_swap, (r_state == S_FLUSH) |=> (r_bank != $past(r_bank)),
        "bank not swapped after rebuild")
    `ASSERT_CLK(a_pend_bound, (r_state == S_PPUSH) |-> ((r_nc + CNT_W'(r_pv)) <= CNT_W'(MAX_LEVELS)),
        "rebuilt skyline exceeds level store")

endmodule
